/* rtl/rfwg_pkg.sv */
// shared width and word type for the root fraction word generator
package rfwg_pkg;
  localparam int FRAC_W = 32;
  typedef logic [FRAC_W-1:0] word_t;
endpackage

/* rtl/root_fraction_word_generator.sv */
// top level: pipelined digit-by-digit cube and square root fraction generator
//
// Accepts one value per cycle (busy is low except while rst_n is asserted) and
// returns the first 32 fractional bits of its cube root and of its square root,
// each shown for exactly one cycle with out_valid. The pipeline length is set
// by the square root chain, which resolves one root bit per pipeline stage by
// restoring digit recurrence on the exact remainder; the cube root needs fewer
// stages, so it holds its operands in the first stages and then resolves one
// bit per stage alongside. The running square of the cube root is carried down
// the pipe, so no stage multiplies.
// The receiver cannot stall.
module root_fraction_word_generator #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                 out_valid,
  output rfwg_pkg::word_t      out_cube_root_fraction,
  output rfwg_pkg::word_t      out_square_root_fraction
);
  import rfwg_pkg::*;

  // cube root of v*2^96: at most (VALUE_WIDTH+2)/3 integer bits plus 32 fraction bits
  localparam int CUBE_BITS = (VALUE_WIDTH + 2) / 3 + FRAC_W;
  localparam int SQ_BITS   = (VALUE_WIDTH + 1) / 2 + FRAC_W;
  localparam int NST       = SQ_BITS;        // pipeline stages, square root is longer
  localparam int CR_W      = 3 * CUBE_BITS;  // radicand width for cube
  localparam int SR_W      = 2 * SQ_BITS;
  localparam int REM_C_W   = 2 * CUBE_BITS + 3;
  localparam int REM_S_W   = SQ_BITS + 2;

  logic [NST:0]                     vld_r;
  logic [CR_W-1:0]                  crad_r [NST+1];
  logic [REM_C_W-1:0]               crem_r [NST+1];
  logic [CUBE_BITS-1:0]             croot_r [NST+1];
  logic [2*CUBE_BITS-1:0]           csq_r [NST+1];
  logic [SR_W-1:0]                  srad_r [NST+1];
  logic [REM_S_W-1:0]               srem_r [NST+1];
  logic [SQ_BITS-1:0]               sroot_r [NST+1];

  assign busy = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    crad_r[0]  <= CR_W'(in_value) << (3 * FRAC_W);
    crem_r[0]  <= '0;
    croot_r[0] <= '0;
    csq_r[0]   <= '0;
    srad_r[0]  <= SR_W'(in_value) << (2 * FRAC_W);
    srem_r[0]  <= '0;
    sroot_r[0] <= '0;
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    // cube: rem = rem*8 + next 3 radicand bits, trial = (2y+1)^3 - (2y)^3
    logic [REM_C_W-1:0] c_rem_sh, c_trial;
    logic [CUBE_BITS-1:0] y;
    logic [2*CUBE_BITS-1:0] ysq;
    logic c_act;
    logic [REM_S_W-1:0] s_rem_sh, s_trial;
    logic [SQ_BITS-1:0] sy;
    always_comb begin
      c_act    = (s >= NST - CUBE_BITS);
      y        = croot_r[s];
      ysq      = csq_r[s];
      c_rem_sh = {crem_r[s][REM_C_W-4:0], crad_r[s][CR_W-1 -: 3]};
      // 12y^2 + 6y + 1 built from the running square
      c_trial  = REM_C_W'({ysq, 3'b000}) + REM_C_W'({ysq, 2'b00}) +
                 REM_C_W'({y, 2'b00}) + REM_C_W'({y, 1'b0}) + REM_C_W'(1);
      sy       = sroot_r[s];
      s_rem_sh = {srem_r[s][REM_S_W-3:0], srad_r[s][SR_W-1 -: 2]};
      s_trial  = {sy, 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!c_act) begin
        crad_r[s+1]  <= crad_r[s];
        crem_r[s+1]  <= crem_r[s];
        croot_r[s+1] <= croot_r[s];
        csq_r[s+1]   <= csq_r[s];
      end else begin
        crad_r[s+1] <= crad_r[s] << 3;
        if (c_rem_sh >= c_trial) begin
          crem_r[s+1]  <= c_rem_sh - c_trial;
          croot_r[s+1] <= {y[CUBE_BITS-2:0], 1'b1};
          // (2y+1)^2 = 4y^2 + 4y + 1
          csq_r[s+1]   <= {ysq[2*CUBE_BITS-3:0], 2'b00} + (2*CUBE_BITS)'({y, 2'b01});
        end else begin
          crem_r[s+1]  <= c_rem_sh;
          croot_r[s+1] <= {y[CUBE_BITS-2:0], 1'b0};
          csq_r[s+1]   <= {ysq[2*CUBE_BITS-3:0], 2'b00};
        end
      end
      srad_r[s+1] <= srad_r[s] << 2;
      if (s_rem_sh >= s_trial) begin
        srem_r[s+1]  <= s_rem_sh - s_trial;
        sroot_r[s+1] <= {sy[SQ_BITS-2:0], 1'b1};
      end else begin
        srem_r[s+1]  <= s_rem_sh;
        sroot_r[s+1] <= {sy[SQ_BITS-2:0], 1'b0};
      end
    end
  end

  assign out_valid                = vld_r[NST];
  assign out_cube_root_fraction   = croot_r[NST][FRAC_W-1:0];
  assign out_square_root_fraction = sroot_r[NST][FRAC_W-1:0];
endmodule

/* rtl/rfwg_checker.sv */
// port-level checks for the root fraction word generator
module rfwg_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid
);
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_busy_in_reset: assert property (@(posedge clk) !rst_n |-> busy)
    else $error("busy low during reset");
  a_no_out_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("result right after reset");
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result during reset");
endmodule

bind root_fraction_word_generator rfwg_checker u_rfwg_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid)
);

/* bench/root_fraction_word_generator_test.sv */
// testbench for the root fraction word generator: random and directed values vs exact roots
`timescale 1ns / 100ps

module root_fraction_word_generator_test;
  import rfwg_pkg::*;

  localparam int VW = 16;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [VW-1:0] value;
    word_t         cube_frac;
    word_t         square_frac;
  } root_words_t;

  // exact floor(cbrt(v * 2^96)) low word, one root bit per step
  function automatic word_t cube_root_word(input logic [VW-1:0] v);
    logic [131:0] target;
    logic [131:0] trial;
    logic [42:0]  root;
    logic [42:0]  cand;
    target = {116'd0, v} << 96;
    root = '0;
    for (int k = 42; k >= 0; k--) begin
      cand = root | (43'd1 << k);
      trial = {89'd0, cand};
      trial = trial * trial * trial;
      if (trial <= target) root = cand;
    end
    return root[31:0];
  endfunction

  function automatic word_t square_root_word(input logic [VW-1:0] v);
    logic [95:0] target;
    logic [95:0] trial;
    logic [47:0] root;
    logic [47:0] cand;
    target = {80'd0, v} << 64;
    root = '0;
    for (int k = 47; k >= 0; k--) begin
      cand = root | (48'd1 << k);
      trial = {48'd0, cand};
      trial = trial * trial;
      if (trial <= target) root = cand;
    end
    return root[31:0];
  endfunction

  class root_scoreboard;
    root_words_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_value(input logic [VW-1:0] v);
      root_words_t w;
      w.value = v;
      w.cube_frac = cube_root_word(v);
      w.square_frac = square_root_word(v);
      pending = {pending, w};
    endfunction

    function void check_words(input word_t cube, input word_t square);
      root_words_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transaction cube=%h square=%h", $time, cube, square);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (cube !== w.cube_frac) begin
        $display("%0t: value %0d cube root fraction expected %h actual %h",
                 $time, w.value, w.cube_frac, cube);
        errors++;
      end
      if (square !== w.square_frac) begin
        $display("%0t: value %0d square root fraction expected %h actual %h",
                 $time, w.value, w.square_frac, square);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [VW-1:0] in_value = '0;
  logic busy;
  logic out_valid;
  word_t out_cube_root_fraction;
  word_t out_square_root_fraction;

  root_scoreboard sb = new();
  int stall_count = 0;

  root_fraction_word_generator #(.VALUE_WIDTH(VW)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_cube_root_fraction(out_cube_root_fraction),
    .out_square_root_fraction(out_square_root_fraction)
  );

  always #5 clk = ~clk;

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_value(in_value);
      if (out_valid) sb.check_words(out_cube_root_fraction, out_square_root_fraction);
      if ((start && !busy) || out_valid) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("root_fraction_word_generator: mismatch");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  task automatic send_value(input logic [VW-1:0] v, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random(input int count, input int idle_pct);
    logic [VW-1:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: v = VW'($urandom_range(300));
        1: v = VW'($urandom_range(40) ** 2);
        default: v = VW'($urandom);
      endcase
      send_value(v, idle_pct);
    end
  endtask

  initial begin
    logic [VW-1:0] directed[$];
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd8, 16'd9, 16'd27,
                 16'd64, 16'd311, 16'd256, 16'd4096, 16'd32768, 16'd46656, 16'd65025,
                 16'd65534, 16'd65535, 16'h5555, 16'haaaa, 16'd65521};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_value(directed[i], 0);
    start <= 1'b0;
    // hold off until the pipeline has emptied
    while (sb.pending.size() != 0) @(posedge clk);
    send_random(650, 10);
    send_random(650, 76);
    send_random(650, 0);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("root_fraction_word_generator: match");
    end else begin
      $display("root_fraction_word_generator: mismatch");
    end
    $finish;
  end
endmodule
